>>> hw/rtl/bleradv_pkg.sv
`default_nettype none

package bleradv_pkg;

  // field widths
  localparam int MAC_W      = 48;
  localparam int UUID_W     = 16;
  localparam int UUID_N     = 6;
  localparam int ADDR_W     = 16;
  localparam int CODE_W     = 8;
  localparam int SENSOR_W   = 8;
  localparam int TIMEOUT_W  = 16;
  localparam int IDLE_W     = 17;
  localparam int CNT_W      = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  // default sensor slots
  localparam int NUM_BUTTONS_DEF = 8;

  // fixed values in the unmasked frame
  localparam logic [7:0] FRAME_B2   = 8'h00;
  localparam logic [7:0] FRAME_B3   = 8'h01;
  localparam logic [7:0] FRAME_B4   = 8'h02;
  localparam logic [7:0] FRAME_B5   = 8'h02;
  localparam logic [7:0] FRAME_B8   = 8'hF9;
  localparam logic [7:0] FRAME_B9   = 8'hF8;
  localparam logic [7:0] FRAME_B10  = 8'hF7;
  localparam logic [7:0] ACTION_BAD = 8'hF7;
  localparam int         PRESS_BIT  = 3;
  localparam logic [4:0] UUID_NEED  = 5'd6;

  localparam logic [IDLE_W-1:0]    IDLE_MAX        = '1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_DEFAULT = 16'd1000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAC_FILTER_ENABLE    = 3'd0,
    REG_MAC_MATCH            = 3'd1,
    REG_REMOTE_FILTER_ENABLE = 3'd2,
    REG_REMOTE_MATCH         = 3'd3,
    REG_IDLE_TIMEOUT_MS      = 3'd4,
    REG_BUTTON_CODES         = 3'd5,
    REG_BUTTON_COUNT         = 3'd6
  } reg_index_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED        = 3'd0,
    ST_MAC_FILTERED    = 3'd1,
    ST_MALFORMED       = 3'd2,
    ST_REMOTE_FILTERED = 3'd3,
    ST_DUPLICATE       = 3'd4,
    ST_BAD_CONST       = 3'd5,
    ST_BAD_ACTION      = 3'd6,
    ST_TICK            = 3'd7
  } status_t;

  typedef struct packed {
    logic                               opcode;
    logic [MAC_W-1:0]                   sender_mac;
    logic                               has_maker_data;
    logic                               has_svc_data;
    logic [4:0]                         uuid_count;
    logic [UUID_N-1:0][UUID_W-1:0]      uuid;
  } item_t;

  typedef struct packed {
    logic                  mac_filter_enable;
    logic [MAC_W-1:0]      mac_match;
    logic                  remote_filter_enable;
    logic [ADDR_W-1:0]     remote_match;
    logic [TIMEOUT_W-1:0]  idle_timeout_ms;
    logic [CFG_DATA_W-1:0] key_codes;
    logic [CNT_W-1:0]      button_count;
  } cfg_t;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor_bits;
    logic [7:0]          prev_action;
    logic [7:0]          prev_mask;
    logic [ADDR_W-1:0]   prev_remote;
    logic [IDLE_W-1:0]   idle_ms;
    logic                recent_activity;
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   remote_addr;
    logic [CODE_W-1:0]   key_code;
    logic                pressed;
    logic                matched;
    logic [SENSOR_W-1:0] sensor_states;
    logic [SENSOR_W-1:0] release_pulse;
    logic                timed_out;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/bleradv_decode.sv
`default_nettype none

module bleradv_decode #(
  parameter int NUM_BUTTONS = bleradv_pkg::NUM_BUTTONS_DEF
) (
  input  bleradv_pkg::item_t   item,
  input  bleradv_pkg::cfg_t    cfg,
  input  bleradv_pkg::state_t  st,
  output bleradv_pkg::result_t res,
  output bleradv_pkg::state_t  st_next
);
  import bleradv_pkg::*;

  // decode of one transaction against current state
  always_comb begin
    logic [7:0]        d [12];
    logic [ADDR_W-1:0] remote;
    logic [IDLE_W-1:0] idle_inc;
    logic              fire;
    logic              pressed;
    logic [CODE_W-1:0] code;
    logic              matched;
    logic [SENSOR_W-1:0] pulse;
    logic [SENSOR_W-1:0] bits;

    st_next = st;
    res     = '0;
    res.status = ST_ACCEPTED;

    // unpack low byte first, then unmask with byte 1
    for (int i = 0; i < UUID_N; i++) begin
      d[2*i]   = item.uuid[i][7:0];
      d[2*i+1] = item.uuid[i][15:8];
    end
    for (int i = 2; i < 12; i++) begin
      d[i] = d[i] ^ d[1];
    end
    remote  = {d[6], d[7]};
    pressed = d[0][PRESS_BIT];
    code    = d[11];

    // idle timer step for a tick
    idle_inc = (st.idle_ms == IDLE_MAX) ? st.idle_ms : st.idle_ms + 1'b1;
    fire     = st.recent_activity && (idle_inc > {1'b0, cfg.idle_timeout_ms});

    // sensor code compare over the slots in use
    matched = 1'b0;
    pulse   = '0;
    bits    = st.sensor_bits;
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      if (CNT_W'(k) < cfg.button_count) begin
        if (cfg.key_codes[8*k +: 8] == code) begin
          matched = 1'b1;
          if (pressed) begin
            bits[k] = 1'b1;
          end else begin
            pulse[k] = 1'b1;
            bits[k]  = 1'b0;
          end
        end else begin
          bits[k] = 1'b0;
        end
      end
    end

    if (item.opcode) begin
      st_next.idle_ms = idle_inc;
      res.status      = ST_TICK;
      if (fire) begin
        st_next.sensor_bits     = '0;
        st_next.recent_activity = 1'b0;
        res.timed_out           = 1'b1;
      end
    end else if (cfg.mac_filter_enable && cfg.mac_match != item.sender_mac) begin
      res.status = ST_MAC_FILTERED;
    end else if (item.has_maker_data || item.has_svc_data || item.uuid_count != UUID_NEED) begin
      res.status = ST_MALFORMED;
    end else if (cfg.remote_filter_enable && cfg.remote_match != remote) begin
      res.status      = ST_REMOTE_FILTERED;
      res.remote_addr = remote;
    end else begin
      // address passed: restart idle timer
      st_next.idle_ms         = '0;
      st_next.recent_activity = 1'b1;
      res.remote_addr         = remote;
      if (st.prev_mask == d[1] && st.prev_action == d[0] && st.prev_remote == remote) begin
        res.status = ST_DUPLICATE;
      end else begin
        st_next.prev_action = d[0];
        st_next.prev_mask   = d[1];
        st_next.prev_remote = remote;
        if (d[2] != FRAME_B2 || d[3] != FRAME_B3 || d[4] != FRAME_B4 ||
            d[5] != FRAME_B5 || d[8] != FRAME_B8 || d[9] != FRAME_B9 ||
            d[10] != FRAME_B10) begin
          res.status = ST_BAD_CONST;
        end else if ((d[0] & ACTION_BAD) != 8'h00) begin
          res.status = ST_BAD_ACTION;
        end else begin
          res.status          = ST_ACCEPTED;
          res.key_code        = code;
          res.pressed         = pressed;
          res.matched         = matched;
          res.release_pulse   = pulse;
          st_next.sensor_bits = bits;
        end
      end
    end

    res.sensor_states = st_next.sensor_bits;
  end

endmodule

`default_nettype wire

>>> hw/rtl/ble_remote_adv_decoder_core.sv
`default_nettype none

// path: a transaction is accepted into the input register, and its result
//   then moves through the decode pass into the output register
// throughput: one transaction per cycle while the output is not stalled, set by
//   the single decode pass between the input register and the result register
// reset: synchronous rst empties both stages, clears the decoder state and
//   loads register defaults (idle timeout 1000 ms, all else zero)
module ble_remote_adv_decoder_core #(
  parameter int NUM_BUTTONS = bleradv_pkg::NUM_BUTTONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_we,
  input  logic [bleradv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bleradv_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [47:0] sender_mac,
  input  logic        has_maker_data,
  input  logic        has_svc_data,
  input  logic [4:0]  uuid_count,
  input  logic [15:0] uuid_0,
  input  logic [15:0] uuid_1,
  input  logic [15:0] uuid_2,
  input  logic [15:0] uuid_3,
  input  logic [15:0] uuid_4,
  input  logic [15:0] uuid_5,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] remote_addr,
  output logic [7:0]  key_code,
  output logic        pressed,
  output logic        matched,
  output logic [7:0]  sensor_states,
  output logic [7:0]  release_pulse,
  output logic        timed_out
);
  import bleradv_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  state_t  st;
  state_t  st_next;
  result_t res_next;
  result_t out_res;
  logic    s2_free;
  logic    s1_adv;
  logic    in_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mac_filter_enable    <= 1'b0;
      cfg.mac_match            <= '0;
      cfg.remote_filter_enable <= 1'b0;
      cfg.remote_match         <= '0;
      cfg.idle_timeout_ms      <= TIMEOUT_DEFAULT;
      cfg.key_codes            <= '0;
      cfg.button_count         <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_MAC_FILTER_ENABLE:    cfg.mac_filter_enable    <= cfg_data[0];
        REG_MAC_MATCH:            cfg.mac_match            <= cfg_data[MAC_W-1:0];
        REG_REMOTE_FILTER_ENABLE: cfg.remote_filter_enable <= cfg_data[0];
        REG_REMOTE_MATCH:         cfg.remote_match         <= cfg_data[ADDR_W-1:0];
        REG_IDLE_TIMEOUT_MS:      cfg.idle_timeout_ms      <= cfg_data[TIMEOUT_W-1:0];
        REG_BUTTON_CODES:         cfg.key_codes            <= cfg_data;
        REG_BUTTON_COUNT:         cfg.button_count         <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  assign s2_free  = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && s2_free;
  assign in_stall = s1_valid && !s2_free;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.opcode         <= opcode;
      s1_item.sender_mac     <= sender_mac;
      s1_item.has_maker_data <= has_maker_data;
      s1_item.has_svc_data   <= has_svc_data;
      s1_item.uuid_count     <= uuid_count;
      s1_item.uuid           <= {uuid_5, uuid_4, uuid_3, uuid_2, uuid_1, uuid_0};
    end
  end

  // decode pass
  bleradv_decode #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_decode (
    .item    (s1_item),
    .cfg     (cfg),
    .st      (st),
    .res     (res_next),
    .st_next (st_next)
  );

  // decoder state, updated as each transaction leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_adv) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= res_next;
    end
  end

  assign status        = out_res.status;
  assign remote_addr   = out_res.remote_addr;
  assign key_code      = out_res.key_code;
  assign pressed       = out_res.pressed;
  assign matched       = out_res.matched;
  assign sensor_states = out_res.sensor_states;
  assign release_pulse = out_res.release_pulse;
  assign timed_out     = out_res.timed_out;

  // a timeout only comes from a tick and leaves every sensor off
  a_timeout_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && timed_out |-> status == ST_TICK && sensor_states == '0)
    else $error("timeout result with sensors still on");

  // a release pulse only from an accepted, matched release
  a_pulse_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && release_pulse != '0 |-> status == ST_ACCEPTED && !pressed && matched)
    else $error("release pulse outside a matched release");

  // the state register tracks the sensor bitmap last reported
  a_state_follows: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid && st.sensor_bits == sensor_states)
    else $error("sensor state and reported bitmap disagree");

  // input stalls only while the input register holds a blocked transaction
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked stage");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bleradv_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_CAP = 200;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [7:0] ACT_PRESS = 8'h01 << PRESS_BIT;
  localparam logic [7:0] ACT_RELEASE = 8'h00;
  localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = 1'b0;
  logic [47:0] sender_mac = '0;
  logic has_maker_data = 1'b0;
  logic has_svc_data = 1'b0;
  logic [4:0] uuid_count = '0;
  logic [15:0] uuid_0 = '0;
  logic [15:0] uuid_1 = '0;
  logic [15:0] uuid_2 = '0;
  logic [15:0] uuid_3 = '0;
  logic [15:0] uuid_4 = '0;
  logic [15:0] uuid_5 = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [15:0] remote_addr;
  logic [7:0] key_code;
  logic pressed;
  logic matched;
  logic [7:0] sensor_states;
  logic [7:0] release_pulse;
  logic timed_out;

  ble_remote_adv_decoder_core uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .sender_mac(sender_mac),
    .has_maker_data(has_maker_data), .has_svc_data(has_svc_data),
    .uuid_count(uuid_count),
    .uuid_0(uuid_0), .uuid_1(uuid_1), .uuid_2(uuid_2),
    .uuid_3(uuid_3), .uuid_4(uuid_4), .uuid_5(uuid_5),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .remote_addr(remote_addr), .key_code(key_code),
    .pressed(pressed), .matched(matched), .sensor_states(sensor_states),
    .release_pulse(release_pulse), .timed_out(timed_out)
  );

  always #1 clk = ~clk;

  // shadow copy of the register file
  logic cfg_mac_en = 1'b0;
  logic [47:0] cfg_mac = '0;
  logic cfg_remote_en = 1'b0;
  logic [15:0] cfg_remote = '0;
  logic [15:0] cfg_timeout = TIMEOUT_DEFAULT;
  logic [63:0] cfg_codes = '0;
  logic [3:0] cfg_count = '0;

  // decoder state as the predictor tracks it
  logic [7:0] sensor_q = '0;
  logic [7:0] last_action = '0;
  logic [7:0] last_mask = '0;
  logic [15:0] last_remote = '0;
  logic [IDLE_W-1:0] idle_q = '0;
  logic activity_q = 1'b0;

  item_t pending_items[$];
  result_t due_results[$];
  item_t offered;
  item_t last_frame;
  bit have_last = 1'b0;
  logic [15:0] remote_pool [4] = '{16'h1234, 16'h0000, 16'hFFFF, 16'h5A5A};

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_accepted = 0;
  int n_timeouts = 0;
  int n_pulses = 0;
  int n_remote_blocked = 0;
  int n_settings = 0;

  // expected outcome of one transaction, advancing the tracked state
  function automatic result_t decode_item(input item_t it);
    result_t r;
    logic [7:0] b [12];
    logic [15:0] addr;
    int n;
    logic [7:0] sc;
    r = '0;
    if (it.opcode) begin
      r.status = ST_TICK;
      if (idle_q != IDLE_MAX) idle_q++;
      if (activity_q && idle_q > {1'b0, cfg_timeout}) begin
        sensor_q = '0;
        activity_q = 1'b0;
        r.timed_out = 1'b1;
      end
    end else if (cfg_mac_en && cfg_mac != it.sender_mac) begin
      r.status = ST_MAC_FILTERED;
    end else if (it.has_maker_data || it.has_svc_data || it.uuid_count != UUID_NEED) begin
      r.status = ST_MALFORMED;
    end else begin
      // unpack low byte first, then unmask with byte 1
      for (int k = 0; k < UUID_N; k++) begin
        b[2*k] = it.uuid[k][7:0];
        b[2*k+1] = it.uuid[k][15:8];
      end
      for (int k = 2; k < 12; k++) b[k] = b[k] ^ b[1];
      addr = {b[6], b[7]};
      r.remote_addr = addr;
      if (cfg_remote_en && cfg_remote != addr) begin
        r.status = ST_REMOTE_FILTERED;
      end else begin
        idle_q = '0;
        activity_q = 1'b1;
        if (last_mask == b[1] && last_action == b[0] && last_remote == addr) begin
          r.status = ST_DUPLICATE;
        end else begin
          last_action = b[0];
          last_mask = b[1];
          last_remote = addr;
          if (b[2] != FRAME_B2 || b[3] != FRAME_B3 || b[4] != FRAME_B4 ||
              b[5] != FRAME_B5 || b[8] != FRAME_B8 || b[9] != FRAME_B9 ||
              b[10] != FRAME_B10) begin
            r.status = ST_BAD_CONST;
          end else if ((b[0] & ACTION_BAD) != 8'h00) begin
            r.status = ST_BAD_ACTION;
          end else begin
            r.status = ST_ACCEPTED;
            r.pressed = b[0][PRESS_BIT];
            r.key_code = b[11];
            n = (cfg_count > NUM_BUTTONS_DEF) ? NUM_BUTTONS_DEF : int'(cfg_count);
            for (int k = 0; k < n; k++) begin
              sc = cfg_codes[8*k +: 8];
              if (sc == b[11]) begin
                r.matched = 1'b1;
                if (r.pressed) begin
                  sensor_q[k] = 1'b1;
                end else begin
                  r.release_pulse[k] = 1'b1;
                  sensor_q[k] = 1'b0;
                end
              end else begin
                sensor_q[k] = 1'b0;
              end
            end
          end
        end
      end
    end
    r.sensor_states = sensor_q;
    return r;
  endfunction

  // well-formed frame: fixed bytes and payload masked with the mask byte
  function automatic item_t make_frame(input logic [7:0] action, input logic [7:0] mask,
                                       input logic [15:0] addr, input logic [7:0] code,
                                       input logic [47:0] mac);
    item_t it;
    logic [7:0] b [12];
    b[0] = action;
    b[1] = mask;
    b[2] = FRAME_B2 ^ mask;
    b[3] = FRAME_B3 ^ mask;
    b[4] = FRAME_B4 ^ mask;
    b[5] = FRAME_B5 ^ mask;
    b[6] = addr[15:8] ^ mask;
    b[7] = addr[7:0] ^ mask;
    b[8] = FRAME_B8 ^ mask;
    b[9] = FRAME_B9 ^ mask;
    b[10] = FRAME_B10 ^ mask;
    b[11] = code ^ mask;
    it = '0;
    it.sender_mac = mac;
    it.uuid_count = UUID_NEED;
    for (int k = 0; k < UUID_N; k++) it.uuid[k] = {b[2*k+1], b[2*k]};
    return it;
  endfunction

  // tick with junk in the fields it does not use
  function automatic item_t tick_item();
    item_t it;
    it = '0;
    it.opcode = 1'b1;
    it.sender_mac = 48'({$urandom, $urandom});
    it.has_maker_data = 1'($urandom);
    it.has_svc_data = 1'($urandom);
    it.uuid_count = 5'($urandom);
    for (int k = 0; k < UUID_N; k++) it.uuid[k] = 16'($urandom);
    return it;
  endfunction

  function automatic logic [47:0] pick_mac();
    if (cfg_mac_en && $urandom_range(99) < 85) return cfg_mac;
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [15:0] pick_remote();
    if (cfg_remote_en && $urandom_range(99) < 80) return cfg_remote;
    if ($urandom_range(99) < 10) return 16'($urandom);
    return remote_pool[$urandom_range(3)];
  endfunction

  function automatic logic [7:0] pick_code();
    int n;
    int k;
    n = (cfg_count > NUM_BUTTONS_DEF) ? NUM_BUTTONS_DEF : int'(cfg_count);
    if (n != 0 && $urandom_range(99) < 75) begin
      k = $urandom_range(n - 1);
      return cfg_codes[8*k +: 8];
    end
    return 8'($urandom);
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (n_errors < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    n_errors++;
  endtask

  // register write, mirrored into the shadow copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAC_FILTER_ENABLE: cfg_mac_en = val[0];
      REG_MAC_MATCH: cfg_mac = val[47:0];
      REG_REMOTE_FILTER_ENABLE: cfg_remote_en = val[0];
      REG_REMOTE_MATCH: cfg_remote = val[15:0];
      REG_IDLE_TIMEOUT_MS: cfg_timeout = val[15:0];
      REG_BUTTON_CODES: cfg_codes = val;
      REG_BUTTON_COUNT: cfg_count = val[3:0];
      default: ;
    endcase
  endtask

  // full register setting, junk in the unused upper bits
  task automatic set_config(input logic mac_en, input logic [47:0] mac, input logic rem_en,
                            input logic [15:0] rem, input logic [15:0] tmo,
                            input logic [63:0] codes, input logic [3:0] cnt);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_MAC_FILTER_ENABLE, {junk[63:1], mac_en});
    write_reg(REG_MAC_MATCH, {junk[63:48], mac});
    write_reg(REG_REMOTE_FILTER_ENABLE, {junk[63:1], rem_en});
    write_reg(REG_REMOTE_MATCH, {junk[63:16], rem});
    write_reg(REG_IDLE_TIMEOUT_MS, {junk[63:16], tmo});
    write_reg(REG_BUTTON_CODES, codes);
    write_reg(REG_BUTTON_COUNT, {junk[63:4], cnt});
    remote_pool[3] = 16'($urandom);
    n_settings++;
  endtask

  // sender stays quiet until every result is back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // random traffic: mostly well-formed frames, bursts of ticks, repeats, broken frames
  task automatic fill_random(input int count);
    int made;
    int sel;
    int burst;
    int j;
    logic [7:0] action;
    item_t it;
    made = 0;
    while (made < count) begin
      sel = $urandom_range(99);
      if (sel < 20) begin
        burst = $urandom_range(1, 12);
        repeat (burst) pending_items.push_back(tick_item());
        made += burst;
      end else if (sel < 28 && have_last) begin
        pending_items.push_back(last_frame);
        made++;
      end else begin
        if ($urandom_range(99) < 85)
          action = $urandom_range(1) ? ACT_PRESS : ACT_RELEASE;
        else
          action = 8'($urandom);
        it = make_frame(action, 8'($urandom), pick_remote(), pick_code(), pick_mac());
        if (sel >= 88) begin
          case ($urandom_range(4))
            0: it.has_maker_data = 1'b1;
            1: it.has_svc_data = 1'b1;
            2: begin
              it.has_maker_data = 1'b1;
              it.has_svc_data = 1'b1;
            end
            3: begin
              it.uuid_count = 5'($urandom);
              if (it.uuid_count == UUID_NEED) it.uuid_count = 5'd7;
              for (int k = 0; k < UUID_N; k++) it.uuid[k] = 16'($urandom);
            end
            default: begin
              // spoil one fixed byte
              case ($urandom_range(6))
                0: j = 2;
                1: j = 3;
                2: j = 4;
                3: j = 5;
                4: j = 8;
                5: j = 9;
                default: j = 10;
              endcase
              it.uuid[j/2][8*(j%2) +: 8] = it.uuid[j/2][8*(j%2) +: 8] ^
                                            8'($urandom_range(1, 255));
            end
          endcase
        end else begin
          last_frame = it;
          have_last = 1'b1;
        end
        pending_items.push_back(it);
        made++;
      end
    end
  endtask

  task automatic run_random(input int sidle, input int rstall, input bit long_hold,
                            input bit mid_pause);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    fill_random(50);
    if (long_hold) hold_requests++;
    if (mid_pause) wait_drained();
    fill_random(50);
    wait_drained();
  endtask

  // driver: offers queued transactions, predicts each one as it is taken
  always @(posedge clk) begin : drive
    item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(decode_item(offered));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          offered = nxt;
          in_valid <= 1'b1;
          opcode <= nxt.opcode;
          sender_mac <= nxt.sender_mac;
          has_maker_data <= nxt.has_maker_data;
          has_svc_data <= nxt.has_svc_data;
          uuid_count <= nxt.uuid_count;
          uuid_0 <= nxt.uuid[0];
          uuid_1 <= nxt.uuid[1];
          uuid_2 <= nxt.uuid[2];
          uuid_3 <= nxt.uuid[3];
          uuid_4 <= nxt.uuid[4];
          uuid_5 <= nxt.uuid[5];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: each result transaction against the oldest prediction
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        flag_mismatch("result with nothing expected, status", 64'(status), 64'(0));
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (want.status == ST_ACCEPTED) n_accepted++;
        if (want.status == ST_REMOTE_FILTERED) n_remote_blocked++;
        if (want.timed_out) n_timeouts++;
        if (want.release_pulse != 0) n_pulses++;
        if (status !== want.status)
          flag_mismatch("status", 64'(status), 64'(want.status));
        if (remote_addr !== want.remote_addr)
          flag_mismatch("remote_addr", 64'(remote_addr), 64'(want.remote_addr));
        if (key_code !== want.key_code)
          flag_mismatch("key_code", 64'(key_code), 64'(want.key_code));
        if (pressed !== want.pressed)
          flag_mismatch("pressed", 64'(pressed), 64'(want.pressed));
        if (matched !== want.matched)
          flag_mismatch("matched", 64'(matched), 64'(want.matched));
        if (sensor_states !== want.sensor_states)
          flag_mismatch("sensor_states", 64'(sensor_states), 64'(want.sensor_states));
        if (release_pulse !== want.release_pulse)
          flag_mismatch("release_pulse", 64'(release_pulse), 64'(want.release_pulse));
        if (timed_out !== want.timed_out)
          flag_mismatch("timed_out", 64'(timed_out), 64'(want.timed_out));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    item_t it;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: filters off, four sensors with a shared code, short timeout
    set_config(1'b0, 48'h0, 1'b0, 16'h0, 16'd2, 64'h3333_3333_FF22_2211, 4'd4);
    pending_items.push_back(tick_item());
    it = make_frame(ACT_PRESS, 8'h5A, 16'h1234, 8'h11, 48'h0);
    pending_items.push_back(it);
    pending_items.push_back(it);
    pending_items.push_back(make_frame(ACT_RELEASE, 8'h5B, 16'h1234, 8'h11, pick_mac()));
    pending_items.push_back(make_frame(ACT_PRESS, 8'h5C, 16'h1234, 8'h22, pick_mac()));
    pending_items.push_back(make_frame(ACT_PRESS, 8'h5D, 16'h1234, 8'h99, pick_mac()));
    pending_items.push_back(make_frame(ACT_PRESS, 8'hFF, 16'hFFFF, 8'hFF, MAC_ONES));
    repeat (3) pending_items.push_back(tick_item());
    pending_items.push_back(make_frame(ACT_RELEASE, 8'h00, 16'h0000, 8'h00, pick_mac()));
    it = make_frame(ACT_PRESS, 8'h61, 16'h1234, 8'h11, pick_mac());
    it.has_maker_data = 1'b1;
    pending_items.push_back(it);
    it.has_maker_data = 1'b0;
    it.has_svc_data = 1'b1;
    pending_items.push_back(it);
    it.has_svc_data = 1'b0;
    it.uuid_count = 5'd5;
    pending_items.push_back(it);
    it.uuid_count = 5'd31;
    pending_items.push_back(it);
    it.uuid_count = 5'd0;
    pending_items.push_back(it);
    it = make_frame(ACT_PRESS, 8'h62, 16'h1234, 8'h11, pick_mac());
    it.uuid[4][7:0] = it.uuid[4][7:0] ^ 8'h01;
    pending_items.push_back(it);
    pending_items.push_back(make_frame(8'hFF, 8'h63, 16'h1234, 8'h11, pick_mac()));
    pending_items.push_back(make_frame(8'h01, 8'h64, 16'h1234, 8'h11, pick_mac()));
    wait_drained();

    // directed: both filters, oversized sensor count, zero timeout
    set_config(1'b1, MAC_ONES, 1'b1, 16'hBEEF, 16'd0, 64'hA7A6_A5A4_A3A2_A1A0, 4'd15);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    it = make_frame(ACT_PRESS, 8'h32, 16'hBEEF, 8'hA7, 48'h0);
    it.has_maker_data = 1'b1;
    pending_items.push_back(it);
    pending_items.push_back(make_frame(ACT_PRESS, 8'h33, 16'hBEEF, 8'hA7, MAC_ONES));
    pending_items.push_back(make_frame(ACT_PRESS, 8'h34, 16'h1234, 8'hA7, MAC_ONES));
    repeat (2) pending_items.push_back(tick_item());
    wait_drained();

    // random phases across settings and idling patterns
    set_config(1'b0, 48'h0, 1'b0, 16'h0, 16'd3, {$urandom, $urandom}, 4'd8);
    run_random(0, 0, 0, 0);
    set_config(1'b0, 48'h0, 1'b0, 16'h0, 16'hFFFF, {$urandom, $urandom}, 4'd2);
    run_random(48, 0, 0, 0);
    set_config(1'b1, 48'h0, 1'b0, 16'h0, 16'd1, {$urandom, $urandom}, 4'd8);
    run_random(0, 48, 1, 0);
    set_config(1'b0, 48'h0, 1'b1, 16'hFFFF, 16'd0, {$urandom, $urandom}, 4'd0);
    run_random(10, 10, 0, 0);
    set_config(1'b1, MAC_ONES, 1'b1, 16'($urandom), 16'd10, {$urandom, $urandom}, 4'd5);
    run_random(0, 0, 0, 1);
    set_config(1'b0, 48'($urandom), 1'b0, 16'($urandom), 16'd7, {$urandom, $urandom},
               4'd15);
    run_random(0, 48, 0, 0);

    // longer timeout: sensors drop only on the tick that passes it
    set_config(1'b0, 48'h0, 1'b0, 16'h0, 16'd60, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pending_items.push_back(make_frame(ACT_PRESS, 8'hC3, 16'h4242, 8'hFF, pick_mac()));
    repeat (62) pending_items.push_back(tick_item());
    wait_drained();

    if (due_results.size() != 0)
      flag_mismatch("results never produced, count", 64'(0), 64'(due_results.size()));
    $display("checked %0d results from %0d transactions over %0d register settings",
             n_checked, n_sent, n_settings);
    $display("packets accepted %0d, remote filtered %0d, release pulses %0d, timeouts %0d",
             n_accepted, n_remote_blocked, n_pulses, n_timeouts);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/bleradv_pkg.sv
hw/rtl/bleradv_decode.sv
hw/rtl/ble_remote_adv_decoder_core.sv
tb/sv/tb_top.sv
